FILE: hdl/rte_pkg.sv
package rte_pkg;

  // fixed field widths
  localparam int unsigned ValueW = 12;
  localparam int unsigned CharW  = 8;

  // largest value that has a numeral
  localparam logic [ValueW-1:0] MaxValue = ValueW'(3999);

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // symbol table, largest weight first
  localparam int unsigned NumSyms = 13;
  localparam int unsigned SymIdxW = 4;

  localparam logic [ValueW-1:0] SymWeight [NumSyms] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };

  localparam logic [CharW-1:0] ChM = 8'h4D;
  localparam logic [CharW-1:0] ChD = 8'h44;
  localparam logic [CharW-1:0] ChC = 8'h43;
  localparam logic [CharW-1:0] ChL = 8'h4C;
  localparam logic [CharW-1:0] ChX = 8'h58;
  localparam logic [CharW-1:0] ChV = 8'h56;
  localparam logic [CharW-1:0] ChI = 8'h49;
  localparam logic [CharW-1:0] ChNone = 8'h00;

  localparam logic [CharW-1:0] SymFirst [NumSyms] = '{
    ChM, ChC, ChD, ChC, ChC, ChX, ChL, ChX, ChX, ChI, ChV, ChI, ChI
  };

  // none marks a single-letter symbol
  localparam logic [CharW-1:0] SymSecond [NumSyms] = '{
    ChNone, ChM, ChNone, ChD, ChNone, ChC, ChNone, ChL, ChNone, ChX, ChNone, ChV, ChNone
  };

  // classified item passed from front to back
  typedef struct packed {
    logic              oor;
    logic [ValueW-1:0] value;
  } item_t;

  // largest symbol whose weight fits in the value
  function automatic logic [SymIdxW-1:0] sym_pick(logic [ValueW-1:0] v);
    logic [SymIdxW-1:0] idx;
    idx = SymIdxW'(NumSyms - 1);
    for (int i = NumSyms - 1; i >= 0; i--) begin
      if (v >= SymWeight[i]) begin
        idx = SymIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: hdl/integer_to_roman_encoder_unit.sv
// channel   | direction | transfer when     | payload
// ----------+-----------+-------------------+---------------------------------------
// input     | in        | push && !full     | value_i (12 bit unsigned)
// result    | out       | pop && !empty     | character_o, last_o, out_of_range_o
//
// the back sequencer emits one letter per cycle while the result is not
// stalled, so an item gives as many results as its numeral has letters (1 to
// 15, 15 for 3888); an out-of-range value gives one result and a zero gives
// none in the back part. the first letter passes the holding stage, the queue
// and the result register before it shows; reset clears all control state at
// once.
// a stalled result holds the sequencer while the front keeps filling the queue.
module integer_to_roman_encoder_unit
  import rte_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [ValueW-1:0] value_i,
  output logic              empty,
  input  logic              pop,
  output logic [CharW-1:0]  character_o,
  output logic              last_o,
  output logic              out_of_range_o
);

  logic  fq_push, fq_full, bq_valid, bq_pop;
  item_t fq_item, bq_item;

  // classify and hold incoming values
  rte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .value_i  (value_i),
    .full     (full),
    .q_push_o (fq_push),
    .q_item_o (fq_item),
    .q_full_i (fq_full)
  );

  // decoupling queue
  rte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_item),
    .full_o  (fq_full),
    .pop_i   (bq_pop),
    .item_o  (bq_item),
    .valid_o (bq_valid)
  );

  // letter sequencer and result register
  rte_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (bq_valid),
    .q_item_i       (bq_item),
    .q_pop_o        (bq_pop),
    .empty          (empty),
    .pop            (pop),
    .character_o    (character_o),
    .last_o         (last_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

FILE: hdl/rte_front.sv
module rte_front
  import rte_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic [ValueW-1:0] value_i,
  output logic              full,
  output logic              q_push_o,
  output item_t             q_item_o,
  input  logic              q_full_i
);

  logic  hold_valid_q, hold_valid_d;
  item_t hold_q, hold_d;
  logic  accept;
  item_t item_in;

  // classify the incoming value
  always_comb begin
    item_in.value = value_i;
    item_in.oor   = (value_i > MaxValue);
  end

  // holding stage, zero values are dropped here
  assign full     = hold_valid_q && q_full_i;
  assign accept   = push && !full;
  assign q_push_o = hold_valid_q && !q_full_i;
  assign q_item_o = hold_q;

  always_comb begin
    hold_valid_d = hold_valid_q && q_full_i;
    hold_d       = hold_q;
    if (accept && (value_i != '0)) begin
      hold_valid_d = 1'b1;
      hold_d       = item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

FILE: hdl/rte_queue.sv
module rte_queue
  import rte_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: hdl/rte_back.sv
module rte_back
  import rte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [CharW-1:0] character_o,
  output logic             last_o,
  output logic             out_of_range_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StEmit   = 3'b010,
    StSecond = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [ValueW-1:0]  rest_q, rest_d;
  logic [CharW-1:0]   second_q, second_d;
  logic               out_valid_q, out_valid_d;
  logic [CharW-1:0]   out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic               out_oor_q, out_oor_d;
  logic               room;
  logic [ValueW-1:0]  cur;
  logic [SymIdxW-1:0] sym;
  logic [ValueW-1:0]  cur_rest;

  assign room = !out_valid_q || pop;

  // one symbol step on the current remainder
  assign cur      = (state_q == StIdle) ? q_item_i.value : rest_q;
  assign sym      = sym_pick(cur);
  assign cur_rest = cur - SymWeight[sym];

  // sequencer, one letter per cycle while the result register has room
  always_comb begin
    state_d     = state_q;
    rest_d      = rest_q;
    second_d    = second_q;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && !pop;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_oor_d   = out_oor_q;
    case (state_q)
      StIdle: begin
        if (q_valid_i && room) begin
          q_pop_o     = 1'b1;
          out_valid_d = 1'b1;
          if (q_item_i.oor) begin
            out_char_d = ChNone;
            out_last_d = 1'b1;
            out_oor_d  = 1'b1;
          end else begin
            out_char_d = SymFirst[sym];
            out_oor_d  = 1'b0;
            rest_d     = cur_rest;
            if (SymSecond[sym] != ChNone) begin
              second_d   = SymSecond[sym];
              out_last_d = 1'b0;
              state_d    = StSecond;
            end else begin
              out_last_d = (cur_rest == '0);
              state_d    = (cur_rest == '0) ? StIdle : StEmit;
            end
          end
        end
      end
      StEmit: begin
        if (room) begin
          out_valid_d = 1'b1;
          out_char_d  = SymFirst[sym];
          out_oor_d   = 1'b0;
          rest_d      = cur_rest;
          if (SymSecond[sym] != ChNone) begin
            second_d   = SymSecond[sym];
            out_last_d = 1'b0;
            state_d    = StSecond;
          end else begin
            out_last_d = (cur_rest == '0);
            state_d    = (cur_rest == '0) ? StIdle : StEmit;
          end
        end
      end
      StSecond: begin
        if (room) begin
          out_valid_d = 1'b1;
          out_char_d  = second_q;
          out_oor_d   = 1'b0;
          out_last_d  = (rest_q == '0);
          state_d     = (rest_q == '0) ? StIdle : StEmit;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q     <= rest_d;
    second_q   <= second_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_oor_q  <= out_oor_d;
  end

  // result register drives the ports
  assign empty          = !out_valid_q;
  assign character_o    = out_char_q;
  assign last_o         = out_last_q;
  assign out_of_range_o = out_oor_q;

endmodule
